// File: hdl/acache_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Codes, register indexes and the tag entry type shared by the ARP cache
// engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package acache_pkg;

	// Commands.
	localparam logic [1:0] CMD_RESOLVE = 2'd0;
	localparam logic [1:0] CMD_FRAME   = 2'd1;
	localparam logic [1:0] CMD_CLOSE   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_BROADCAST = 3'd1;
	localparam logic [2:0] ST_NEED_REQ  = 3'd2;
	localparam logic [2:0] ST_LOCAL_ERR = 3'd3;
	localparam logic [2:0] ST_DROPPED   = 3'd4;
	localparam logic [2:0] ST_UPDATED   = 3'd5;
	localparam logic [2:0] ST_REPLY     = 3'd6;
	localparam logic [2:0] ST_CLOSED    = 3'd7;

	// Configuration register indexes.
	localparam logic REG_MY_IP  = 1'b0;
	localparam logic REG_MY_MAC = 1'b1;

	// ARP field values.
	localparam logic [15:0] OPC_REQUEST = 16'h0001;
	localparam logic [15:0] PROTO_IP    = 16'h0800;

	// Hash fold and the remainder unit that reduces it.
	localparam int             FOLD_W      = 15;
	localparam logic [14:0]    FOLD_MASK   = 15'h7fff;
	localparam int             HASH_STEPS  = 5;
	localparam int             HASH_CYCLES = FOLD_W / HASH_STEPS;
	localparam int             HASH_CW     = (HASH_CYCLES > 1) ? $clog2(HASH_CYCLES) : 1;

	// One tag entry: in_use is bit 33 and complete is bit 32, above the address.
	typedef struct packed {
		logic        in_use;
		logic        complete;
		logic [31:0] ip;
	} tag_t;

endpackage

`default_nettype wire

// File: hdl/acache_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module acache_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire  logic                 clk,
	input  wire  logic                 wr_en,
	input  wire  logic [AW-1:0]        wr_addr,
	input  wire  logic [WIDTH-1:0]     wr_data,
	input  wire  logic                 rd_en,
	input  wire  logic [AW-1:0]        rd_addr,
	output logic       [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/acache_hash.sv
// ----------------------------------------------------------------------------
// ARP cache bucket hash
// Folds an IPv4 address to 15 bits, reduces it modulo the bucket count with
// an iterative restoring remainder and returns the bucket's first table
// index.
// ----------------------------------------------------------------------------
`default_nettype none

module acache_hash #(
	parameter int BUCKETS     = 19,
	parameter int BUCKET_SIZE = 5,
	parameter int AW          = 7
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	input  wire  logic [31:0]   ip,
	output logic                done,
	output logic [AW-1:0]       base
);

	localparam int           RW = ((BUCKETS > 1) ? $clog2(BUCKETS) : 0) + 1;
	localparam logic [RW-1:0] BK = RW'(BUCKETS);

	logic [acache_pkg::FOLD_W-1:0]  fold_q;
	logic [RW-1:0]                  rem_q;
	logic [acache_pkg::HASH_CW-1:0] cnt_q;
	logic                           run_q;
	logic                           fin_q;
	logic [acache_pkg::FOLD_W-1:0]  fold_nx;
	logic [RW-1:0]                  rem_nx;

	// Each cycle shifts several dividend bits into the remainder.
	always_comb begin
		fold_nx = fold_q;
		rem_nx  = rem_q;
		for (int k = 0; k < acache_pkg::HASH_STEPS; k++) begin
			rem_nx  = (rem_nx << 1) | RW'(fold_nx[acache_pkg::FOLD_W-1]);
			fold_nx = fold_nx << 1;
			if (rem_nx >= BK) begin
				rem_nx = rem_nx - BK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done  <= 1'b0;
			fin_q <= 1'b0;
			if (start) begin
				fold_q <= (ip[30:16] ^ ip[14:0]) & acache_pkg::FOLD_MASK;
				rem_q  <= '0;
				cnt_q  <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				fold_q <= fold_nx;
				rem_q  <= rem_nx;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == acache_pkg::HASH_CW'(acache_pkg::HASH_CYCLES - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				base <= AW'(rem_q) * AW'(BUCKET_SIZE);
				done <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/arp_cache_engine_core.sv
// ----------------------------------------------------------------------------
// ARP cache engine
// Hashed ARP cache with resolve, received-frame and close commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low, and exactly one
// result word follows on status, mac, reply_ip and duplicate, marked by done
// for a single cycle; the receiver must take it then. Busy drops in the cycle
// that done is shown, so the next command may start there. Commands that need
// no table lookup (broadcast, local address, dropped or duplicate frames,
// unknown commands) give their result straight from the decode state. A lookup
// runs the hash unit, reads the tag RAM once per bucket slot and ends with one
// read-modify-write step. Close sweeps the tag RAM one entry a cycle and
// answers when the sweep ends. After reset the same sweep runs with busy high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_engine_core #(
	parameter int BUCKETS     = 19,
	parameter int BUCKET_SIZE = 5
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	output logic                busy,
	input  wire  logic [1:0]    cmd,
	input  wire  logic [31:0]   ip_addr,
	input  wire  logic [31:0]   target_ip,
	input  wire  logic [47:0]   sender_mac,
	input  wire  logic [15:0]   opcode,
	input  wire  logic [15:0]   protocol,
	input  wire  logic          frame_short,
	input  wire  logic          cfg_wr_en,
	input  wire  logic          cfg_index,
	input  wire  logic [47:0]   cfg_data,
	output logic                done,
	output logic [2:0]          status,
	output logic [47:0]         mac,
	output logic [31:0]         reply_ip,
	output logic                duplicate
);

	localparam int TABLE_SIZE = BUCKETS * BUCKET_SIZE;
	localparam int AW         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int NW         = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
	localparam int TAG_W      = $bits(acache_pkg::tag_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_HASH,
		S_SCAN,
		S_TAIL,
		S_ACT
	} state_t;

	state_t           state_q;
	logic             busy_q;
	logic [31:0]      my_ip_q;
	logic [47:0]      my_mac_q;

	logic [1:0]       cmd_q;
	logic [31:0]      ip_q;
	logic [31:0]      target_ip_q;
	logic [47:0]      sender_mac_q;
	logic [15:0]      opcode_q;
	logic [15:0]      protocol_q;
	logic             frame_short_q;

	logic [AW-1:0]    clr_q;
	logic             clr_close_q;
	logic [AW-1:0]    base_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    rp_q;
	logic             rdv_s1;
	logic [NW-1:0]    slot_s1;
	logic             hit_q;
	logic [NW-1:0]    hit_off_q;
	logic             hit_done_q;
	logic [47:0]      hit_mac_q;
	logic             free_q;
	logic [NW-1:0]    free_off_q;

	logic             done_q;
	logic [2:0]       status_q;
	logic [47:0]      mac_q;
	logic [31:0]      reply_ip_q;
	logic             duplicate_q;

	// RAM ports.
	logic             tag_we;
	logic             mac_we;
	logic [AW-1:0]    wr_addr;
	acache_pkg::tag_t tag_wdata;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	acache_pkg::tag_t tag_rdata;
	logic [47:0]      mac_rdata;

	// Hash unit.
	logic             hash_start;
	logic             hash_done;
	logic [AW-1:0]    hash_base;

	// Decode and action results.
	logic             dec_lookup;
	logic             dec_close;
	logic [2:0]       dec_status;
	logic [47:0]      dec_mac;
	logic [31:0]      dec_rip;
	logic             dec_dup;
	logic             is_resolve;
	logic             tip_local;
	logic             act_alloc;
	logic [AW-1:0]    act_slot;
	logic [2:0]       act_status;
	logic [47:0]      act_mac;
	logic [31:0]      act_rip;

	function automatic logic is_bcast(input logic [31:0] a);
		logic [31:0] hmask;
		logic [31:0] host;
		if (!a[31]) begin
			hmask = 32'h00ff_ffff;
		end else if (a[31:30] == 2'b10) begin
			hmask = 32'h0000_ffff;
		end else if (a[31:29] == 3'b110) begin
			hmask = 32'h0000_00ff;
		end else begin
			hmask = 32'hffff_ffff;
		end
		host = a & hmask;
		return (host == 32'h0) || (host == hmask);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q  <= '0;
			my_mac_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == acache_pkg::REG_MY_IP) begin
				my_ip_q <= cfg_data[31:0];
			end else begin
				my_mac_q <= cfg_data;
			end
		end
	end

	// Decode: results of the commands that finish without touching the table, and the lookup and close flags.
	always_comb begin
		dec_lookup = 1'b0;
		dec_close  = 1'b0;
		dec_status = acache_pkg::ST_DROPPED;
		dec_mac    = '0;
		dec_rip    = '0;
		dec_dup    = 1'b0;
		case (cmd_q)
			acache_pkg::CMD_RESOLVE: begin
				if (is_bcast(ip_q)) begin
					dec_status = acache_pkg::ST_BROADCAST;
					dec_mac    = '1;
				end else if (ip_q == my_ip_q) begin
					dec_status = acache_pkg::ST_LOCAL_ERR;
				end else begin
					dec_lookup = 1'b1;
				end
			end
			acache_pkg::CMD_FRAME: begin
				if (frame_short_q || protocol_q != acache_pkg::PROTO_IP ||
				    sender_mac_q == my_mac_q) begin
					dec_status = acache_pkg::ST_DROPPED;
				end else if (ip_q == my_ip_q) begin
					dec_dup = 1'b1;
					if (opcode_q == acache_pkg::OPC_REQUEST) begin
						dec_status = acache_pkg::ST_REPLY;
						dec_mac    = sender_mac_q;
						dec_rip    = ip_q;
					end
				end else begin
					dec_lookup = 1'b1;
				end
			end
			acache_pkg::CMD_CLOSE: begin
				dec_close = 1'b1;
			end
			default: begin
				dec_status = acache_pkg::ST_DROPPED;
			end
		endcase
	end

	// Read-modify-write step after the bucket scan.
	always_comb begin
		is_resolve = (cmd_q == acache_pkg::CMD_RESOLVE);
		tip_local  = (target_ip_q == my_ip_q);
		act_alloc  = !hit_q && (is_resolve || tip_local);
		if (hit_q) begin
			act_slot = base_q + AW'(hit_off_q);
		end else if (free_q) begin
			act_slot = base_q + AW'(free_off_q);
		end else begin
			act_slot = base_q + AW'(rp_q);
		end
		act_mac = '0;
		act_rip = '0;
		if (is_resolve) begin
			if (hit_q && hit_done_q) begin
				act_status = acache_pkg::ST_HIT;
				act_mac    = hit_mac_q;
			end else begin
				act_status = acache_pkg::ST_NEED_REQ;
				act_rip    = ip_q;
			end
		end else if (!tip_local) begin
			act_status = hit_q ? acache_pkg::ST_UPDATED : acache_pkg::ST_DROPPED;
		end else if (opcode_q == acache_pkg::OPC_REQUEST) begin
			act_status = acache_pkg::ST_REPLY;
			act_mac    = sender_mac_q;
			act_rip    = ip_q;
		end else begin
			act_status = acache_pkg::ST_UPDATED;
		end
	end

	always_comb begin
		hash_start = (state_q == S_DECODE) && dec_lookup;
		rd_en      = (state_q == S_SCAN);
		rd_addr    = base_q + AW'(n_q);
		tag_we     = 1'b0;
		mac_we     = 1'b0;
		wr_addr    = act_slot;
		tag_wdata  = '0;
		case (state_q)
			S_CLEAR: begin
				tag_we  = 1'b1;
				wr_addr = clr_q;
			end
			S_ACT: begin
				tag_we             = act_alloc || (!is_resolve && hit_q);
				mac_we             = !is_resolve && (hit_q || act_alloc);
				tag_wdata.in_use   = 1'b1;
				tag_wdata.complete = !is_resolve;
				tag_wdata.ip       = ip_q;
			end
			default: begin
				tag_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			busy_q      <= 1'b1;
			clr_q       <= '0;
			clr_close_q <= 1'b0;
			rp_q        <= '0;
			n_q         <= '0;
			rdv_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= '0;
			mac_q       <= '0;
			reply_ip_q  <= '0;
			duplicate_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rdv_s1 <= 1'b0;
			// Bucket scan: the data of the slot read last cycle arrives now.
			if (rdv_s1) begin
				if (!hit_q && tag_rdata.in_use && tag_rdata.ip == ip_q) begin
					hit_q      <= 1'b1;
					hit_off_q  <= slot_s1;
					hit_done_q <= tag_rdata.complete;
					hit_mac_q  <= mac_rdata;
				end
				if (!free_q && !tag_rdata.in_use) begin
					free_q     <= 1'b1;
					free_off_q <= slot_s1;
				end
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						state_q     <= S_IDLE;
						busy_q      <= 1'b0;
						done_q      <= clr_close_q;
						status_q    <= acache_pkg::ST_CLOSED;
						mac_q       <= '0;
						reply_ip_q  <= '0;
						duplicate_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q         <= cmd;
						ip_q          <= ip_addr;
						target_ip_q   <= target_ip;
						sender_mac_q  <= sender_mac;
						opcode_q      <= opcode;
						protocol_q    <= protocol;
						frame_short_q <= frame_short;
						busy_q        <= 1'b1;
						state_q       <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (dec_close) begin
						clr_q       <= '0;
						clr_close_q <= 1'b1;
						state_q     <= S_CLEAR;
					end else if (dec_lookup) begin
						state_q <= S_HASH;
					end else begin
						state_q     <= S_IDLE;
						busy_q      <= 1'b0;
						done_q      <= 1'b1;
						status_q    <= dec_status;
						mac_q       <= dec_mac;
						reply_ip_q  <= dec_rip;
						duplicate_q <= dec_dup;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						base_q  <= hash_base;
						n_q     <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rdv_s1  <= 1'b1;
					slot_s1 <= n_q;
					n_q     <= n_q + 1'b1;
					if (n_q == NW'(BUCKET_SIZE - 1)) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					// A full bucket takes the round-robin victim.
					if (act_alloc && !free_q) begin
						rp_q <= (rp_q == NW'(BUCKET_SIZE - 1)) ? '0 : rp_q + 1'b1;
					end
					state_q     <= S_IDLE;
					busy_q      <= 1'b0;
					done_q      <= 1'b1;
					status_q    <= act_status;
					mac_q       <= act_mac;
					reply_ip_q  <= act_rip;
					duplicate_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	acache_hash #(
		.BUCKETS     (BUCKETS),
		.BUCKET_SIZE (BUCKET_SIZE),
		.AW          (AW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.ip     (ip_q),
		.done   (hash_done),
		.base   (hash_base)
	);

	acache_ram #(
		.WIDTH (TAG_W),
		.DEPTH (TABLE_SIZE)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (tag_we),
		.wr_addr (wr_addr),
		.wr_data (tag_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (tag_rdata)
	);

	acache_ram #(
		.WIDTH (48),
		.DEPTH (TABLE_SIZE)
	) u_mac_ram (
		.clk     (clk),
		.wr_en   (mac_we),
		.wr_addr (wr_addr),
		.wr_data (sender_mac_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (mac_rdata)
	);

	assign busy      = busy_q;
	assign done      = done_q;
	assign status    = status_q;
	assign mac       = mac_q;
	assign reply_ip  = reply_ip_q;
	assign duplicate = duplicate_q;

	// A result word always comes with the engine free for the next command.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a command was taken");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tag_we && rd_en))
		else $error("tag RAM written during a bucket scan");

	a_reply_ip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != acache_pkg::ST_NEED_REQ && status != acache_pkg::ST_REPLY
		|-> reply_ip == 32'h0)
		else $error("reply_ip set on a status that carries none");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= NW'(BUCKET_SIZE - 1))
		else $error("replacement pointer out of bucket");

endmodule

`default_nettype wire

// File: verif/arp_cache_check_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache scoreboard
// Mirror of the hashed ARP table that works out the result word of every
// accepted command and checks the words that the engine returns.
// ----------------------------------------------------------------------------
package arp_cache_check_pkg;

	localparam int TABLE_BUCKETS = 19;
	localparam int TABLE_WAYS    = 5;
	localparam int TABLE_SLOTS   = TABLE_BUCKETS * TABLE_WAYS;

	localparam logic [1:0] FLAG_IN_USE   = 2'b01;
	localparam logic [1:0] FLAG_COMPLETE = 2'b10;

	typedef struct {
		logic [2:0]  status;
		logic [47:0] mac;
		logic [31:0] reply_ip;
		logic        duplicate;
	} answer_t;

	class arp_cache_mirror;
		logic [31:0] own_ip;
		logic [47:0] own_mac;
		logic [31:0] slot_ip [TABLE_SLOTS];
		logic [47:0] slot_mac [TABLE_SLOTS];
		logic [1:0]  slot_flags [TABLE_SLOTS];
		int unsigned victim;
		answer_t     pending_answers[$];
		int unsigned errors;

		function new();
			own_ip  = '0;
			own_mac = '0;
			victim  = 0;
			errors  = 0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_ip[i]    = '0;
				slot_mac[i]   = '0;
				slot_flags[i] = '0;
			end
		endfunction

		function void set_reg(logic idx, logic [47:0] data);
			if (idx == acache_pkg::REG_MY_IP) begin
				own_ip = data[31:0];
			end else begin
				own_mac = data;
			end
		endfunction

		// First slot of the bucket: the 15-bit fold of the address, modulo the
		// bucket count.
		function int bucket_base(logic [31:0] a);
			logic [14:0] fold;
			fold = a[30:16] ^ a[14:0];
			return (int'(fold) % TABLE_BUCKETS) * TABLE_WAYS;
		endfunction

		function bit is_broadcast(logic [31:0] a);
			logic [31:0] hmask;
			if (!a[31]) begin
				hmask = 32'h00ff_ffff;
			end else if (a[31:30] == 2'b10) begin
				hmask = 32'h0000_ffff;
			end else if (a[31:29] == 3'b110) begin
				hmask = 32'h0000_00ff;
			end else begin
				hmask = 32'hffff_ffff;
			end
			return (a & hmask) == 0 || (a & hmask) == hmask;
		endfunction

		function int find_slot(logic [31:0] a);
			int base;
			base = bucket_base(a);
			for (int n = 0; n < TABLE_WAYS; n++) begin
				if (slot_flags[base + n] != 0 && slot_ip[base + n] == a)
					return base + n;
			end
			return -1;
		endfunction

		// A full bucket gives up the slot at the shared round-robin pointer.
		// The slot keeps its old MAC until a frame completes it.
		function int claim_slot(logic [31:0] a);
			int base;
			int s;
			base = bucket_base(a);
			s = -1;
			for (int n = 0; n < TABLE_WAYS; n++) begin
				if (s < 0 && slot_flags[base + n] == 0)
					s = base + n;
			end
			if (s < 0) begin
				s = base + int'(victim);
				victim = (victim + 1) % TABLE_WAYS;
			end
			slot_ip[s]    = a;
			slot_flags[s] = FLAG_IN_USE;
			return s;
		endfunction

		function void take_command(logic [1:0] c, logic [31:0] ip, logic [31:0] tip,
				logic [47:0] smac, logic [15:0] op, logic [15:0] proto,
				logic short_frame);
			answer_t ans;
			int      s;
			bit      changed;
			ans = '{acache_pkg::ST_DROPPED, '0, '0, 1'b0};
			case (c)
				acache_pkg::CMD_RESOLVE: begin
					if (is_broadcast(ip)) begin
						ans.status = acache_pkg::ST_BROADCAST;
						ans.mac    = '1;
					end else if (ip == own_ip) begin
						ans.status = acache_pkg::ST_LOCAL_ERR;
					end else begin
						s = find_slot(ip);
						if (s < 0)
							s = claim_slot(ip);
						if ((slot_flags[s] & FLAG_COMPLETE) != 0) begin
							ans.status = acache_pkg::ST_HIT;
							ans.mac    = slot_mac[s];
						end else begin
							ans.status   = acache_pkg::ST_NEED_REQ;
							ans.reply_ip = ip;
						end
					end
				end
				acache_pkg::CMD_FRAME: begin
					if (short_frame || proto != acache_pkg::PROTO_IP || smac == own_mac) begin
						ans.status = acache_pkg::ST_DROPPED;
					end else if (ip == own_ip) begin
						// Someone else claims our address: the table is left alone.
						ans.duplicate = 1'b1;
						if (op == acache_pkg::OPC_REQUEST) begin
							ans.status   = acache_pkg::ST_REPLY;
							ans.mac      = smac;
							ans.reply_ip = ip;
						end
					end else begin
						changed = 1'b0;
						s = find_slot(ip);
						if (s >= 0) begin
							slot_mac[s]   = smac;
							slot_flags[s] = slot_flags[s] | FLAG_COMPLETE;
							changed = 1'b1;
						end
						if (tip != own_ip) begin
							ans.status = changed ? acache_pkg::ST_UPDATED
								: acache_pkg::ST_DROPPED;
						end else begin
							if (s < 0) begin
								s = claim_slot(ip);
								slot_mac[s]   = smac;
								slot_flags[s] = slot_flags[s] | FLAG_COMPLETE;
							end
							if (op == acache_pkg::OPC_REQUEST) begin
								ans.status   = acache_pkg::ST_REPLY;
								ans.mac      = smac;
								ans.reply_ip = ip;
							end else begin
								ans.status = acache_pkg::ST_UPDATED;
							end
						end
					end
				end
				acache_pkg::CMD_CLOSE: begin
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (slot_flags[i] != 0) begin
							slot_ip[i]    = '0;
							slot_flags[i] = '0;
						end
					end
					ans.status = acache_pkg::ST_CLOSED;
				end
				default: begin
				end
			endcase
			pending_answers.push_back(ans);
		endfunction

		function void compare_answer(answer_t got);
			answer_t want;
			if (pending_answers.size() == 0) begin
				$error("result word with no command waiting: status %0d", got.status);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.mac !== want.mac) begin
				$error("mac: expected %h, actual %h", want.mac, got.mac);
				errors++;
			end
			if (got.reply_ip !== want.reply_ip) begin
				$error("reply_ip: expected %h, actual %h", want.reply_ip, got.reply_ip);
				errors++;
			end
			if (got.duplicate !== want.duplicate) begin
				$error("duplicate: expected %0b, actual %0b", want.duplicate, got.duplicate);
				errors++;
			end
		endfunction
	endclass

endpackage

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// ARP cache engine testbench
// Drives resolve, frame, close and unused commands through the command port,
// changes the node address between phases, and checks every result word
// against a mirror of the hashed table.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [15:0] OPC_REPLY = 16'h0002;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [31:0] ip_addr;
	logic [31:0] target_ip;
	logic [47:0] sender_mac;
	logic [15:0] opcode;
	logic [15:0] protocol;
	logic        frame_short;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [47:0] cfg_data;
	logic        done;
	logic [2:0]  status;
	logic [47:0] mac;
	logic [31:0] reply_ip;
	logic        duplicate;

	arp_cache_check_pkg::arp_cache_mirror mirror = new();
	int              sender_idle_pct;
	// Three groups of addresses that share one bucket each, more than a bucket
	// holds, so that replacement is reached often.
	logic [31:0]     mates [3][8];

	arp_cache_engine_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.ip_addr     (ip_addr),
		.target_ip   (target_ip),
		.sender_mac  (sender_mac),
		.opcode      (opcode),
		.protocol    (protocol),
		.frame_short (frame_short),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.mac         (mac),
		.reply_ip    (reply_ip),
		.duplicate   (duplicate)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			mirror.compare_answer('{status, mac, reply_ip, duplicate});
	end

	task automatic send_command(logic [1:0] c, logic [31:0] ip, logic [31:0] tip,
			logic [47:0] smac, logic [15:0] op, logic [15:0] proto, logic short_frame);
		// While the sender idles the fields carry noise.
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start       = 1'b0;
			cmd         = 2'($urandom());
			ip_addr     = $urandom();
			target_ip   = $urandom();
			sender_mac  = {16'($urandom()), 32'($urandom())};
			opcode      = 16'($urandom());
			protocol    = 16'($urandom());
			frame_short = 1'($urandom());
		end
		@(negedge clk);
		start       = 1'b1;
		cmd         = c;
		ip_addr     = ip;
		target_ip   = tip;
		sender_mac  = smac;
		opcode      = op;
		protocol    = proto;
		frame_short = short_frame;
		do @(posedge clk); while (busy);
		mirror.take_command(c, ip, tip, smac, op, proto, short_frame);
	endtask

	task automatic write_reg(logic idx, logic [47:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		mirror.set_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Lowers start and waits for every result word still owed.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		for (int w = 0; w < 400 && mirror.pending_answers.size() > 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return mates[$urandom_range(2)][$urandom_range(7)];
		else if (r < 90)
			return mirror.own_ip;
		else
			return $urandom();
	endfunction

	task automatic run_random(int count);
		int          k;
		logic [31:0] ip;
		logic [31:0] tip;
		logic [47:0] smac;
		logic [15:0] op;
		logic [15:0] proto;
		int          r;
		for (int n = 0; n < count; n++) begin
			k     = $urandom_range(99);
			ip    = pick_addr();
			tip   = ($urandom_range(1) == 0) ? mirror.own_ip : pick_addr();
			smac  = ($urandom_range(19) == 0) ? mirror.own_mac
				: {16'($urandom()), 32'($urandom())};
			r     = $urandom_range(19);
			op    = (r < 9) ? acache_pkg::OPC_REQUEST : (r < 18) ? OPC_REPLY
				: 16'($urandom());
			proto = ($urandom_range(24) == 0) ? 16'($urandom()) : acache_pkg::PROTO_IP;
			if (k < 40) begin
				send_command(acache_pkg::CMD_RESOLVE, ip, tip, smac, op, proto,
					1'($urandom()));
			end else if (k < 92) begin
				send_command(acache_pkg::CMD_FRAME, ip, tip, smac, op, proto,
					$urandom_range(24) == 0);
			end else if (k < 95) begin
				send_command(acache_pkg::CMD_CLOSE, ip, tip, smac, op, proto,
					1'($urandom()));
			end else if (k < 98) begin
				send_command(CMD_UNUSED, ip, tip, smac, op, proto, 1'($urandom()));
			end else begin
				send_command(2'($urandom()), $urandom(), $urandom(),
					{16'($urandom()), 32'($urandom())}, 16'($urandom()),
					16'($urandom()), 1'($urandom()));
			end
		end
	endtask

	initial begin
		logic [31:0] cand;
		logic [47:0] peer_mac;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		ip_addr     = '0;
		target_ip   = '0;
		sender_mac  = '0;
		opcode      = '0;
		protocol    = '0;
		frame_short = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = 1'b0;
		cfg_data    = '0;
		sender_idle_pct = 16;
		peer_mac = 48'h0a1b_2c3d_4e5f;

		for (int g = 0; g < 3; g++) begin
			for (int m = 0; m < 8; m++) begin
				cand = $urandom();
				while (mirror.bucket_base(cand) != (g * 7) * arp_cache_check_pkg::TABLE_WAYS
						|| mirror.is_broadcast(cand))
					cand = $urandom();
				mates[g][m] = cand;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The engine clears its table after reset but takes register writes.
		write_reg(acache_pkg::REG_MY_IP, 48'h0000_c0a8_0001);
		write_reg(acache_pkg::REG_MY_MAC, 48'h0200_0000_0001);

		// Host parts of all zeros or all ones per address class, a class D address,
		// the all-ones and all-zero addresses, then our own address.
		send_command(acache_pkg::CMD_RESOLVE, 32'h0a00_0000, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'h0aff_ffff, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'hac10_ffff, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'hc0a8_00ff, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'he000_0001, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'hffff_ffff, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, 32'h0000_0000, '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, mirror.own_ip, '0, '0, '0, '0, 1'b0);
		// A miss allocates, a second resolve still finds it incomplete, a reply
		// frame completes it and then it hits.
		send_command(acache_pkg::CMD_RESOLVE, mates[0][0], '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, mates[0][0], '0, '0, '0, '0, 1'b0);
		send_command(acache_pkg::CMD_FRAME, mates[0][0], mates[1][0], '1, OPC_REPLY,
			acache_pkg::PROTO_IP, 1'b0);
		send_command(acache_pkg::CMD_RESOLVE, mates[0][0], '0, '0, '0, '0, 1'b0);
		// Frames that are short, of another protocol, or sent by this node.
		send_command(acache_pkg::CMD_FRAME, mates[0][0], mirror.own_ip, peer_mac,
			acache_pkg::OPC_REQUEST, acache_pkg::PROTO_IP, 1'b1);
		send_command(acache_pkg::CMD_FRAME, mates[0][0], mirror.own_ip, peer_mac,
			acache_pkg::OPC_REQUEST, 16'hffff, 1'b0);
		send_command(acache_pkg::CMD_FRAME, mates[0][0], mirror.own_ip, mirror.own_mac,
			acache_pkg::OPC_REQUEST, acache_pkg::PROTO_IP, 1'b0);
		// Duplicate address, once as a request and once with an odd opcode.
		send_command(acache_pkg::CMD_FRAME, mirror.own_ip, mates[0][1], peer_mac,
			acache_pkg::OPC_REQUEST, acache_pkg::PROTO_IP, 1'b0);
		send_command(acache_pkg::CMD_FRAME, mirror.own_ip, mates[0][1], peer_mac, 16'hffff,
			acache_pkg::PROTO_IP, 1'b0);
		// Unknown sender not aimed at us, then insertions aimed at us.
		send_command(acache_pkg::CMD_FRAME, mates[1][1], mates[0][1], '0,
			acache_pkg::OPC_REQUEST, acache_pkg::PROTO_IP, 1'b0);
		send_command(acache_pkg::CMD_FRAME, mates[1][1], mirror.own_ip, peer_mac,
			acache_pkg::OPC_REQUEST, acache_pkg::PROTO_IP, 1'b0);
		send_command(acache_pkg::CMD_FRAME, mates[1][2], mirror.own_ip, peer_mac, 16'h0000,
			acache_pkg::PROTO_IP, 1'b0);
		// Fill the first bucket and push one past it into the replacement path.
		for (int m = 1; m <= 5; m++)
			send_command(acache_pkg::CMD_RESOLVE, mates[0][m], '0, '0, '0, '0, 1'b0);
		send_command(CMD_UNUSED, '1, '1, '1, '1, '1, 1'b1);
		send_command(acache_pkg::CMD_CLOSE, '0, '0, '0, '0, '0, 1'b0);

		run_random(350);

		settle();
		write_reg(acache_pkg::REG_MY_IP, 48'h0000_ffff_ffff);
		write_reg(acache_pkg::REG_MY_MAC, 48'hffff_ffff_ffff);
		sender_idle_pct = 82;
		run_random(350);

		settle();
		write_reg(acache_pkg::REG_MY_IP, 48'h0);
		write_reg(acache_pkg::REG_MY_MAC, 48'h0);
		sender_idle_pct = 0;
		run_random(200);

		// Our address now sits in a shared bucket that the cache also fills.
		settle();
		write_reg(acache_pkg::REG_MY_IP, {16'h0, mates[2][3]});
		write_reg(acache_pkg::REG_MY_MAC, {16'($urandom()), 32'($urandom())});
		run_random(200);

		settle();
		if (mirror.pending_answers.size() != 0) begin
			$error("%0d result words never arrived", mirror.pending_answers.size());
			mirror.errors++;
		end
		repeat (20) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
